/* rtl/catmull_rom_curve_sampler_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_CURVE_SAMPLER_UNIT_MACROS_SVH
`define CATMULL_ROM_CURVE_SAMPLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define CRS_ASSERT(label, clk, rst, prop, msg)
`define CRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/crs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_pkg
// Types, constants and arithmetic helpers of the Catmull-Rom curve sampler.
// ----------------------------------------------------------------------------
package crs_pkg;

   localparam int SAMPLES    = 20;
   localparam int COORD_W    = 32;
   localparam int IDX_W      = 6;
   localparam int U_W        = 17;
   localparam int OP_W       = 38;
   localparam int PROD_W     = OP_W + U_W + 1;
   localparam int PIPE_DEPTH = 6;

   localparam int JQ_DEPTH = 2;
   localparam int JQ_AW    = $clog2(JQ_DEPTH);
   localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

   // u_j = (j*2^17 + D) / (2D), D = SAMPLES-1, stepped as quotient/remainder
   localparam int U_DEN   = 2 * (SAMPLES - 1);
   localparam int U_QSTEP = 131072 / U_DEN;
   localparam int U_RSTEP = 131072 % U_DEN;
   localparam int U_R_W   = $clog2(2 * U_DEN);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [OP_W-1:0]    op_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic [U_W-1:0]            u_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [U_R_W-1:0]          urem_type;

   localparam idx_type   LAST_IDX  = IDX_W'(SAMPLES - 1);
   localparam u_type     U_QINC    = U_W'(U_QSTEP);
   localparam u_type     U_ONE     = U_W'(65536);
   localparam urem_type  U_RINC    = U_R_W'(U_RSTEP);
   localparam urem_type  U_RDEN    = U_R_W'(U_DEN);
   localparam urem_type  U_R_INIT  = U_R_W'(SAMPLES - 1);
   localparam logic [1:0] HELD_FULL = 2'd3;
   localparam op_type    SAT_HI    = OP_W'(2147483647);
   localparam op_type    SAT_LO    = -SAT_HI - OP_W'(1);

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      point_type p0;
      point_type p1;
      point_type p2;
      point_type p3;
   } job_type;

   typedef struct packed {
      op_type    a;
      op_type    b;
      op_type    c;
      coord_type p1;
   } coef_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      logic      start_curve;
   } req_type;

   typedef struct packed {
      coord_type sample_x;
      coord_type sample_y;
      coord_type sample_z;
      idx_type   sample_index;
      logic      last_sample;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      idx_type index;
      logic    last;
   } ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jq_status_type;

   typedef enum logic [0:0] {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   function automatic coef_type coef_of(coord_type p0, coord_type p1, coord_type p2,
                                        coord_type p3);
      op_type   e0;
      op_type   e1;
      op_type   e2;
      op_type   e3;
      op_type   d;
      coef_type r;
      e0 = OP_W'(p0);
      e1 = OP_W'(p1);
      e2 = OP_W'(p2);
      e3 = OP_W'(p3);
      d = e1 - e2;
      r.a = e2 - e0;
      r.b = (e0 <<< 1) + (e2 <<< 2) - (e1 <<< 2) - e1 - e3;
      r.c = (d <<< 1) + d + e3 - e0;
      r.p1 = p1;
      return r;
   endfunction

   // round to nearest, halves up
   function automatic op_type round16(prod_type v);
      prod_type s;
      s = v + PROD_W'(32768);
      return OP_W'(s >>> 16);
   endfunction

   function automatic coord_type finish(coord_type p1, op_type t);
      op_type    s;
      op_type    h;
      coord_type r;
      s = (OP_W'(p1) <<< 1) + t + OP_W'(1);
      h = s >>> 1;
      if (h > SAT_HI) begin
         r = COORD_W'(SAT_HI);
      end else if (h < SAT_LO) begin
         r = COORD_W'(SAT_LO);
      end else begin
         r = COORD_W'(h);
      end
      return r;
   endfunction

endpackage

/* rtl/crs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_front
// Holds the last three control points and issues one segment job per point once three are held.
// ----------------------------------------------------------------------------
module crs_front import crs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   input  req_type       req_item,
   output logic          req_full,
   input  jq_status_type jq_status,
   output logic          jq_push,
   output job_type       jq_job
);

   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic [1:0] cnt_eff;
   logic       accept;
   point_type  pt;
   point_type  held_ff [3];

   assign req_full = jq_status.full;
   assign accept   = req_push && !jq_status.full;

   always_comb begin
      pt.x = req_item.point_x;
      pt.y = req_item.point_y;
      pt.z = req_item.point_z;
      jq_job.p0 = held_ff[0];
      jq_job.p1 = held_ff[1];
      jq_job.p2 = held_ff[2];
      jq_job.p3 = pt;
   end

   always_comb begin
      cnt_eff = req_item.start_curve ? 2'd0 : cnt_ff;
      cnt_in  = cnt_ff;
      jq_push = 1'b0;
      if (accept) begin
         if (cnt_eff == HELD_FULL) begin
            jq_push = 1'b1;
            cnt_in  = HELD_FULL;
         end else begin
            cnt_in = cnt_eff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (cnt_eff == HELD_FULL) begin
            held_ff[0] <= held_ff[1];
            held_ff[1] <= held_ff[2];
            held_ff[2] <= pt;
         end else begin
            for (int i = 0; i < 3; i++) begin
               if (cnt_eff == 2'(i)) begin
                  held_ff[i] <= pt;
               end
            end
         end
      end
   end

endmodule

/* rtl/crs_job_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_job_queue
// Short queue of segment jobs between the front and the evaluator.
// ----------------------------------------------------------------------------
`include "catmull_rom_curve_sampler_unit_macros.svh"

module crs_job_queue import crs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  job_type       push_job,
   input  logic          pop,
   output job_type       head,
   output jq_status_type status
);

   job_type          q_ff [JQ_DEPTH];
   logic [JQ_AW-1:0] wr_ff;
   logic [JQ_AW-1:0] rd_ff;
   logic [JQ_CW-1:0] cnt_ff;

   assign status.full  = (cnt_ff == JQ_CW'(JQ_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign head         = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + JQ_AW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + JQ_AW'(1);
         end
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + JQ_CW'(1);
            2'b01:   cnt_ff <= cnt_ff - JQ_CW'(1);
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= push_job;
      end
   end

   `CRS_ASSERT(a_jq_no_overflow, clock, reset, push |-> !status.full, "job pushed into full queue")
   `CRS_ASSERT(a_jq_no_underflow, clock, reset, pop |-> !status.empty, "job popped from empty queue")

endmodule

/* rtl/crs_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_lane
// Six-stage Horner pipeline for one coordinate.
// ----------------------------------------------------------------------------
module crs_lane import crs_pkg::*; (
   input  logic      clock,
   input  logic      adv,
   input  coef_type  coef,
   input  u_type     u,
   output coord_type sample
);

   logic signed [U_W:0] u_s0;
   logic signed [U_W:0] u_s2;
   logic signed [U_W:0] u_s4;

   prod_type  prod1_ff, prod1_in;
   op_type    b1_ff, a1_ff;
   coord_type p1_1_ff;
   u_type     u1_ff;

   op_type    op2_ff, op2_in;
   op_type    a2_ff;
   coord_type p1_2_ff;
   u_type     u2_ff;

   prod_type  prod3_ff, prod3_in;
   op_type    a3_ff;
   coord_type p1_3_ff;
   u_type     u3_ff;

   op_type    op4_ff, op4_in;
   coord_type p1_4_ff;
   u_type     u4_ff;

   prod_type  prod5_ff, prod5_in;
   coord_type p1_5_ff;

   coord_type sample_ff, sample_in;

   assign u_s0 = $signed({1'b0, u});
   assign u_s2 = $signed({1'b0, u2_ff});
   assign u_s4 = $signed({1'b0, u4_ff});

   assign prod1_in  = PROD_W'(coef.c) * PROD_W'(u_s0);
   assign op2_in    = b1_ff + round16(prod1_ff);
   assign prod3_in  = PROD_W'(op2_ff) * PROD_W'(u_s2);
   assign op4_in    = a3_ff + round16(prod3_ff);
   assign prod5_in  = PROD_W'(op4_ff) * PROD_W'(u_s4);
   assign sample_in = finish(p1_5_ff, round16(prod5_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         prod1_ff  <= prod1_in;
         b1_ff     <= coef.b;
         a1_ff     <= coef.a;
         p1_1_ff   <= coef.p1;
         u1_ff     <= u;
         op2_ff    <= op2_in;
         a2_ff     <= a1_ff;
         p1_2_ff   <= p1_1_ff;
         u2_ff     <= u1_ff;
         prod3_ff  <= prod3_in;
         a3_ff     <= a2_ff;
         p1_3_ff   <= p1_2_ff;
         u3_ff     <= u2_ff;
         op4_ff    <= op4_in;
         p1_4_ff   <= p1_3_ff;
         u4_ff     <= u3_ff;
         prod5_ff  <= prod5_in;
         p1_5_ff   <= p1_4_ff;
         sample_ff <= sample_in;
      end
   end

   assign sample = sample_ff;

endmodule

/* rtl/crs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_back
// Sample sequencer, control pipeline and three coordinate lanes.
// ----------------------------------------------------------------------------
`include "catmull_rom_curve_sampler_unit_macros.svh"

module crs_back import crs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  job_type       head,
   input  jq_status_type jq_status,
   output logic          jq_pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_type       rsp_item
);

   seq_state_type state_ff, state_in;
   idx_type       j_ff, j_in;
   u_type         u_ff, u_in;
   urem_type      r_ff, r_in;
   urem_type      r_sum;
   coef_type      coef_ff [3];
   ctl_type       ctl_ff [PIPE_DEPTH];
   coord_type     lane_out [3];
   logic          adv;
   logic          issue;
   logic          issue_last;
   logic          load;

   assign adv        = !ctl_ff[PIPE_DEPTH-1].valid || rsp_pop;
   assign issue      = (state_ff == SEQ_RUN) && adv;
   assign issue_last = issue && (j_ff == LAST_IDX);
   assign r_sum      = r_ff + U_RINC;

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      u_in     = u_ff;
      r_in     = r_ff;
      load     = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            if (!jq_status.empty) begin
               load     = 1'b1;
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            if (issue) begin
               if (j_ff == LAST_IDX) begin
                  if (!jq_status.empty) begin
                     load = 1'b1;
                  end else begin
                     state_in = SEQ_IDLE;
                  end
               end else begin
                  j_in = j_ff + IDX_W'(1);
                  if (r_sum >= U_RDEN) begin
                     r_in = r_sum - U_RDEN;
                     u_in = u_ff + U_QINC + U_W'(1);
                  end else begin
                     r_in = r_sum;
                     u_in = u_ff + U_QINC;
                  end
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
      if (load) begin
         j_in = '0;
         u_in = '0;
         r_in = U_R_INIT;
      end
   end

   assign jq_pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         j_ff     <= '0;
         u_ff     <= '0;
         r_ff     <= U_R_INIT;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         u_ff     <= u_in;
         r_ff     <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         coef_ff[0] <= coef_of(head.p0.x, head.p1.x, head.p2.x, head.p3.x);
         coef_ff[1] <= coef_of(head.p0.y, head.p1.y, head.p2.y, head.p3.y);
         coef_ff[2] <= coef_of(head.p0.z, head.p1.z, head.p2.z, head.p3.z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (adv) begin
         ctl_ff[0].valid <= (state_ff == SEQ_RUN);
         ctl_ff[0].index <= j_ff;
         ctl_ff[0].last  <= (j_ff == LAST_IDX);
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      crs_lane u_lane (
         .clock  (clock),
         .adv    (adv),
         .coef   (coef_ff[k]),
         .u      (u_ff),
         .sample (lane_out[k])
      );
   end

   assign rsp_empty             = !ctl_ff[PIPE_DEPTH-1].valid;
   assign rsp_item.sample_x     = lane_out[0];
   assign rsp_item.sample_y     = lane_out[1];
   assign rsp_item.sample_z     = lane_out[2];
   assign rsp_item.sample_index = ctl_ff[PIPE_DEPTH-1].index;
   assign rsp_item.last_sample  = ctl_ff[PIPE_DEPTH-1].last;

   `CRS_ASSERT(a_last_u_is_one, clock, reset, issue_last |-> (u_ff == U_ONE), "final sample u is not one")
   `CRS_ASSERT_NEXT(a_index_step, clock, reset, ctl_ff[PIPE_DEPTH-1].valid && adv && !ctl_ff[PIPE_DEPTH-1].last, ctl_ff[PIPE_DEPTH-1].valid && (ctl_ff[PIPE_DEPTH-1].index == $past(ctl_ff[PIPE_DEPTH-1].index) + IDX_W'(1)), "sample index did not advance by one")

endmodule

/* rtl/catmull_rom_curve_sampler_unit.sv */
// Path: a closing control point's first sample passes through the job queue, the
//   coefficient load and the six-stage Horner pipeline to the result ports.
// Throughput: one sample per cycle while results are popped; back-to-back segments of
//   SAMPLES samples follow without a gap. A lone idle segment first passes the idle load state.
// Reset: synchronous, active high; clears held-point count, job queue and pipeline control.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_curve_sampler_unit
// Uniform Catmull-Rom curve sampler: control points in, segment samples out.
// ----------------------------------------------------------------------------
module catmull_rom_curve_sampler_unit import crs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_item,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_item
);

   jq_status_type jq_status;
   logic          jq_push;
   logic          jq_pop;
   job_type       jq_job;
   job_type       jq_head;

   crs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .jq_status (jq_status),
      .jq_push   (jq_push),
      .jq_job    (jq_job)
   );

   crs_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (jq_push),
      .push_job (jq_job),
      .pop      (jq_pop),
      .head     (jq_head),
      .status   (jq_status)
   );

   crs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (jq_head),
      .jq_status (jq_status),
      .jq_pop    (jq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

/* tb/catmull_rom_curve_sampler_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_curve_sampler_unit_tb
// Sends control points through the request port and predicts every segment
// sample in a scoreboard class. Popped samples are checked field by field
// against the oldest prediction. Both sides stall at random. The stimulus is
// a directed set of extremes and curve restarts, followed by random curves.
// ----------------------------------------------------------------------------
module catmull_rom_curve_sampler_unit_tb;
   import crs_pkg::*;

   localparam int        TOTAL_POINTS   = 460;
   localparam int        WATCHDOG_LIMIT = 1000;
   localparam int        SETTLE_CYCLES  = 30;
   localparam coord_type CMAX           = 32'sh7fff_ffff;
   localparam coord_type CMIN           = 32'sh8000_0000;
   localparam longint    COORD_MAX      = 64'sd2147483647;
   localparam longint    COORD_MIN      = -64'sd2147483648;

   class sample_book;
      coord_type held_x[3];
      coord_type held_y[3];
      coord_type held_z[3];
      int        held;
      rsp_type   pending_samples[$];
      int        failures;
      int        reported;
      int        checked;
      int        saturated;

      function new();
         int i;
         for (i = 0; i < 3; i++) begin
            held_x[i] = '0;
            held_y[i] = '0;
            held_z[i] = '0;
         end
         held      = 0;
         failures  = 0;
         reported  = 0;
         checked   = 0;
         saturated = 0;
      endfunction

      function longint rnd16(longint v);
         return (v + 64'sd32768) >>> 16;
      endfunction

      function coord_type blend(coord_type q0, coord_type q1, coord_type q2,
                                coord_type q3, longint u);
         longint p0;
         longint p1;
         longint p2;
         longint p3;
         longint a;
         longint b;
         longint c;
         longint t;
         p0 = q0;
         p1 = q1;
         p2 = q2;
         p3 = q3;
         a = p2 - p0;
         b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
         c = -p0 + 3 * p1 - 3 * p2 + p3;
         t = rnd16(c * u);
         t = rnd16((b + t) * u);
         t = rnd16((a + t) * u);
         t = (2 * p1 + t + 1) >>> 1;
         if (t > COORD_MAX) begin
            t = COORD_MAX;
            saturated++;
         end else if (t < COORD_MIN) begin
            t = COORD_MIN;
            saturated++;
         end
         return coord_type'(t);
      endfunction

      function void note_point(req_type p);
         rsp_type s;
         longint  u;
         int      j;
         if (p.start_curve) held = 0;
         if (held < 3) begin
            held_x[held] = p.point_x;
            held_y[held] = p.point_y;
            held_z[held] = p.point_z;
            held++;
            return;
         end
         for (j = 0; j < SAMPLES; j++) begin
            u = (longint'(j) * 131072 + (SAMPLES - 1)) / (2 * (SAMPLES - 1));
            s.sample_x     = blend(held_x[0], held_x[1], held_x[2], p.point_x, u);
            s.sample_y     = blend(held_y[0], held_y[1], held_y[2], p.point_y, u);
            s.sample_z     = blend(held_z[0], held_z[1], held_z[2], p.point_z, u);
            s.sample_index = idx_type'(j);
            s.last_sample  = (j == SAMPLES - 1);
            pending_samples.push_back(s);
         end
         held_x[0] = held_x[1]; held_x[1] = held_x[2]; held_x[2] = p.point_x;
         held_y[0] = held_y[1]; held_y[1] = held_y[2]; held_y[2] = p.point_y;
         held_z[0] = held_z[1]; held_z[1] = held_z[2]; held_z[2] = p.point_z;
      endfunction

      function void check_sample(rsp_type got);
         rsp_type want;
         checked++;
         if (pending_samples.size() == 0) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("ERROR: sample beat with nothing expected: x=%h y=%h z=%h idx=%0d last=%b",
                        got.sample_x, got.sample_y, got.sample_z, got.sample_index,
                        got.last_sample);
            end
            return;
         end
         want = pending_samples.pop_front();
         if (got.sample_x !== want.sample_x || got.sample_y !== want.sample_y ||
             got.sample_z !== want.sample_z || got.sample_index !== want.sample_index ||
             got.last_sample !== want.last_sample) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("ERROR: sample mismatch at %0t", $realtime);
               $display("   x   exp %h got %h", want.sample_x, got.sample_x);
               $display("   y   exp %h got %h", want.sample_y, got.sample_y);
               $display("   z   exp %h got %h", want.sample_z, got.sample_z);
               $display("   idx exp %0d got %0d", want.sample_index, got.sample_index);
               $display("   last exp %b got %b", want.last_sample, got.last_sample);
            end
         end
      endfunction

      function int pending();
         return pending_samples.size();
      endfunction
   endclass

   logic    clock;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_item = '0;
   logic    rsp_empty;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_item;

   sample_book book;
   int         points_sent    = 0;
   int         curves_started = 0;
   int         drains         = 0;
   int         idle_cycles    = 0;
   int         tx_calm        = 0;
   int         rx_calm        = 0;

   catmull_rom_curve_sampler_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic req_type mk_point(coord_type x, coord_type y, coord_type z, logic s);
      req_type p;
      p.point_x     = x;
      p.point_y     = y;
      p.point_z     = z;
      p.start_curve = s;
      return p;
   endfunction

   function automatic coord_type pick_coord(int style, coord_type prev);
      coord_type v;
      case (style)
         0: v = coord_type'($urandom);
         1: v = prev + coord_type'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         default: begin
            case ($urandom_range(0, 5))
               0: v = CMAX;
               1: v = CMIN;
               2: v = '0;
               3: v = coord_type'($urandom_range(0, 3)) - 32'sd2;
               4: v = prev ^ 32'h8000_0001;
               default: v = coord_type'($urandom);
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic send_point(req_type p);
      int gap;
      gap = draw_gap(tx_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= p;
      do @(posedge clock); while (req_full);
      book.note_point(p);
      points_sent++;
      if (p.start_curve) curves_started++;
   endtask

   task automatic hold_off();
      req_push <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
      drains++;
   endtask

   // receiver: random pop stalls, one check per popped beat
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_gap(rx_calm);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         book.check_sample(rsp_item);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no beat on either side for %0d cycles, %0d samples outstanding",
                  idle_cycles, book.pending());
         $display("catmull_rom_curve_sampler_unit_tb: FAIL");
         $finish;
      end
   end

   initial begin
      req_type   p;
      coord_type px;
      coord_type py;
      coord_type pz;
      int        kind;
      int        style;
      int        len;
      int        k;
      int        break_at;
      logic      first_start;
      int        next_drain;

      book = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: first point without a start flag, saturating extremes
      send_point(mk_point('0, '0, '0, 1'b0));
      send_point(mk_point(CMAX, CMIN, 32'sd1, 1'b0));
      send_point(mk_point(CMIN, CMAX, -32'sd1, 1'b0));
      send_point(mk_point(CMAX, CMIN, 32'sh0001_0000, 1'b0));
      send_point(mk_point(CMIN, CMAX, 32'sh8000_0001, 1'b0));
      // overshoot past both ends of the range
      send_point(mk_point(CMIN, CMAX, CMIN, 1'b1));
      send_point(mk_point(CMAX, CMIN, CMAX, 1'b0));
      send_point(mk_point(CMAX, CMIN, CMAX, 1'b0));
      send_point(mk_point(CMIN, CMAX, CMIN, 1'b0));
      // restart after two held points
      send_point(mk_point(32'sd1, 32'sd2, 32'sd3, 1'b1));
      send_point(mk_point(32'sd4, 32'sd5, 32'sd6, 1'b0));
      send_point(mk_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_7fff, 1'b1));
      send_point(mk_point(32'sh0000_8000, 32'sh0000_7fff, -32'sh0000_8000, 1'b0));
      send_point(mk_point(-32'sd1, 32'sd1, 32'sh0000_ffff, 1'b0));
      send_point(mk_point(32'sh7fff_0000, -32'sh7fff_0000, 32'sd3, 1'b0));
      // restart with three held, then a start where a segment would close
      send_point(mk_point(32'sh1234_5678, 32'shedcb_a987, 32'sh0f0f_0f0f, 1'b1));
      send_point(mk_point(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_0001, 1'b0));
      send_point(mk_point(32'sh3333_3333, 32'shcccc_cccc, 32'shffff_fffe, 1'b0));
      send_point(mk_point(32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, 1'b1));
      send_point(mk_point(32'sh0005_8000, 32'sh0001_8000, -32'sh0002_8000, 1'b0));
      send_point(mk_point(32'sh0007_0001, -32'sh0000_0003, 32'sh0000_0005, 1'b0));
      send_point(mk_point(32'sh0006_ffff, 32'sh0002_0000, 32'shffff_8000, 1'b0));
      hold_off();

      px = '0;
      py = '0;
      pz = '0;
      next_drain = points_sent + 150;
      while (points_sent < TOTAL_POINTS) begin
         kind     = $urandom_range(0, 9);
         style    = $urandom_range(0, 3);
         if (style == 3) style = 1;
         break_at = -1;
         case (kind)
            0: begin
               len         = $urandom_range(1, 3);
               first_start = 1'b1;
            end
            1: begin
               len         = $urandom_range(1, 4);
               first_start = 1'b0;
            end
            2: begin
               len         = $urandom_range(4, 9);
               first_start = 1'b1;
               break_at    = $urandom_range(1, len - 1);
            end
            default: begin
               len         = $urandom_range(4, 10);
               first_start = 1'b1;
            end
         endcase
         for (k = 0; k < len; k++) begin
            px = pick_coord(style, px);
            py = pick_coord(style, py);
            pz = pick_coord(style, pz);
            p  = mk_point(px, py, pz, (k == 0) ? first_start : (k == break_at));
            send_point(p);
         end
         if (points_sent >= next_drain) begin
            hold_off();
            next_drain = points_sent + 150;
         end
      end

      hold_off();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d control points on %0d started curves, %0d sample beats checked.",
               points_sent, curves_started, book.checked);
      $display("%0d coordinates saturated, %0d full drains, %0d mismatching beats.",
               book.saturated, drains, book.failures);
      if (book.failures == 0 && book.pending() == 0) begin
         $display("catmull_rom_curve_sampler_unit_tb: PASS");
      end else begin
         $display("catmull_rom_curve_sampler_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
